[src/tmsf_pkg.sv]
package tmsf_pkg;

	localparam int unsigned SampleW  = 16;
	localparam int unsigned SumW     = 20;
	localparam int unsigned ValueW   = 18;
	localparam int unsigned GainW    = 2;
	localparam int unsigned ErrW     = 2;
	localparam int unsigned CountW   = 4;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CountW-1:0] RunLength   = CountW'(10);
	localparam int unsigned       MeanShift   = 3;
	localparam int unsigned       NarrowShift = 4;

	localparam logic [SampleW-1:0] LimitReset  = 16'd32768;
	localparam logic               TwelveReset = 1'b0;
	localparam logic [GainW-1:0]   GainReset   = 2'd2;

	typedef enum logic [ErrW-1:0] {
		ERR_NONE  = 2'd0,
		ERR_BUS   = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LIMIT  = 2'd0,
		REG_TWELVE = 2'd1,
		REG_GAIN   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SampleW-1:0] limit;
		logic               twelve;
		logic [GainW-1:0]   gain;
	} cfg_t;

	typedef struct packed {
		logic              emit;
		logic [ValueW-1:0] value;
		err_t              error_code;
	} result_t;

endpackage

[src/tmsf_in_if.sv]
interface tmsf_in_if;
	logic                          valid;
	logic                          ready;
	logic [tmsf_pkg::SampleW-1:0]  raw_word;
	logic                          bus_fault;

	modport source (output valid, output raw_word, output bus_fault, input ready);
	modport sink (input valid, input raw_word, input bus_fault, output ready);
endinterface

[src/tmsf_out_if.sv]
interface tmsf_out_if;
	logic                         valid;
	logic                         ready;
	logic [tmsf_pkg::ValueW-1:0]  value;
	logic [tmsf_pkg::ErrW-1:0]    error_code;

	modport source (output valid, output value, output error_code, input ready);
	modport sink (input valid, input value, input error_code, output ready);
endinterface

[src/tmsf_cfg_if.sv]
interface tmsf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tmsf_pkg::CfgIdxW-1:0]   index;
	logic [tmsf_pkg::CfgDataW-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/tmsf_run_acc.sv]
module tmsf_run_acc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [tmsf_pkg::SampleW-1:0]  raw_word,
	input  logic                          bus_fault,
	input  tmsf_pkg::cfg_t                cfg,
	output tmsf_pkg::result_t             result
);

	localparam int unsigned ProdW = tmsf_pkg::SumW - tmsf_pkg::MeanShift + tmsf_pkg::GainW;

	logic [tmsf_pkg::CountW-1:0]  count_q;
	logic [tmsf_pkg::SumW-1:0]    sum_q;
	logic [tmsf_pkg::SampleW-1:0] max_q;
	logic [tmsf_pkg::SampleW-1:0] min_q;

	logic [tmsf_pkg::SampleW-1:0] sample;
	logic                         bad;
	logic                         done;
	logic [tmsf_pkg::SampleW-1:0] max_n;
	logic [tmsf_pkg::SampleW-1:0] min_n;
	logic [tmsf_pkg::SumW-1:0]    sum_n;
	logic [tmsf_pkg::CountW-1:0]  count_n;
	logic [tmsf_pkg::SumW-1:0]    diff;
	logic [tmsf_pkg::SumW-tmsf_pkg::MeanShift-1:0] trimmed;
	logic [ProdW-1:0]             prod;

	always_comb begin
		sample = cfg.twelve ? (raw_word >> tmsf_pkg::NarrowShift) : raw_word;
		bad    = bus_fault || (sample >= cfg.limit);
		// first sample of a run seeds both extremes
		max_n  = ((count_q == '0) || (sample > max_q)) ? sample : max_q;
		min_n  = ((count_q == '0) || (sample < min_q)) ? sample : min_q;
		sum_n  = sum_q + tmsf_pkg::SumW'(sample);
		count_n = count_q + tmsf_pkg::CountW'(1);
		done   = !bad && (count_n == tmsf_pkg::RunLength);
		diff   = sum_n - tmsf_pkg::SumW'(max_n) - tmsf_pkg::SumW'(min_n);
		trimmed = diff[tmsf_pkg::SumW-1:tmsf_pkg::MeanShift];
		prod   = ProdW'(trimmed) * ProdW'(cfg.gain);

		result.emit  = bad || done;
		result.value = bad ? '0 : prod[tmsf_pkg::ValueW-1:0];
		if (bus_fault) begin
			result.error_code = tmsf_pkg::ERR_BUS;
		end else if (bad) begin
			result.error_code = tmsf_pkg::ERR_RANGE;
		end else begin
			result.error_code = tmsf_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= '0;
		end else if (advance) begin
			if (bad || done) begin
				count_q <= '0;
				sum_q   <= '0;
				max_q   <= '0;
				min_q   <= '0;
			end else begin
				count_q <= count_n;
				sum_q   <= sum_n;
				max_q   <= max_n;
				min_q   <= min_n;
			end
		end
	end

endmodule

[src/tmsf_out_reg.sv]
module tmsf_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  tmsf_pkg::result_t result,
	output logic              out_free,
	tmsf_out_if.source        results
);

	logic                          valid_q;
	logic [tmsf_pkg::ValueW-1:0]   value_q;
	tmsf_pkg::err_t                err_q;

	// slot is free when empty or being drained this cycle
	assign out_free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance && result.emit) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			value_q <= result.value;
			err_q   <= result.error_code;
		end
	end

	assign results.valid      = valid_q;
	assign results.value      = value_q;
	assign results.error_code = err_q;

endmodule

[src/trimmed_mean_sample_filter.sv]
// Channel   Dir  Payload                      Transaction when
// samples   in   raw_word[15:0], bus_fault    valid && ready
// results   out  value[17:0], error_code[1:0] valid && ready
// cfg       in   index[1:0], data[15:0]       valid && ready (ready is always high)
//
// One sample per clock unless stalled; results load as samples leave the input register.
// The run state update, trimming subtract and gain multiply sit in one stage
// between the input register and the output register.
// arst_n clears the run, the pipeline valids and loads the register defaults.
// A result held at the output stalls the input register, even for samples that end
// no run; the input takes a sample whenever its register is empty or advancing.
module trimmed_mean_sample_filter (
	input  logic       clk,
	input  logic       arst_n,
	tmsf_in_if.sink    samples,
	tmsf_out_if.source results,
	tmsf_cfg_if.sink   cfg
);

	// configuration registers
	tmsf_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit  <= tmsf_pkg::LimitReset;
			cfg_q.twelve <= tmsf_pkg::TwelveReset;
			cfg_q.gain   <= tmsf_pkg::GainReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				tmsf_pkg::REG_LIMIT:  cfg_q.limit  <= cfg.data;
				tmsf_pkg::REG_TWELVE: cfg_q.twelve <= cfg.data[0];
				tmsf_pkg::REG_GAIN:   cfg_q.gain   <= cfg.data[tmsf_pkg::GainW-1:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	// input register
	logic                         valid_s1;
	logic [tmsf_pkg::SampleW-1:0] raw_s1;
	logic                         fault_s1;
	logic                         out_free;
	logic                         advance;
	tmsf_pkg::result_t            result;

	// advance the held sample whenever the output slot can take a result
	assign advance       = valid_s1 && out_free;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			raw_s1   <= samples.raw_word;
			fault_s1 <= samples.bus_fault;
		end
	end

	// run accumulator: sum, extremes, count and result computation
	tmsf_run_acc u_run_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.raw_word  (raw_s1),
		.bus_fault (fault_s1),
		.cfg       (cfg_q),
		.result    (result)
	);

	// output register
	tmsf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.result   (result),
		.out_free (out_free),
		.results  (results)
	);

	// an error result never carries a value
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.error_code != tmsf_pkg::ERR_NONE) |-> results.value == '0)
		else $error("error result with nonzero value");

	// a stalled sample stays in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register lost a sample");

	// a new result is loaded only into a free output slot
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.emit |-> !results.valid || results.ready)
		else $error("result overwrote a pending result");

endmodule
